// ===== rtl/clle_pkg.sv =====
// Package: sizes, codes, state encoding and helpers of the linked list engine.
`timescale 1ns / 1ps

package clle_pkg;

	localparam int NODES     = 16;
	localparam int IDX_W     = $clog2(NODES);
	localparam int LINK_W    = IDX_W + 1;
	localparam int VAL_W     = 32;
	localparam int REQ_W     = 3;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 4;
	localparam int RES_LIMIT = 16;
	localparam int DUMP_MAX  = (NODES < RES_LIMIT) ? NODES : RES_LIMIT;
	localparam int CNT_W     = $clog2(DUMP_MAX);

	typedef logic [LINK_W-1:0] link_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// null marker: one past the last node
	localparam link_t NIL = LINK_W'(NODES);

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_HEAD   = 3'd0,
		REQ_INS_TAIL   = 3'd1,
		REQ_INS_SORTED = 3'd2,
		REQ_DELETE     = 3'd3,
		REQ_DUMP       = 3'd4
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_WALK,
		S_CMP,
		S_LINK,
		S_DEL,
		S_EMIT,
		S_DUMP_RD,
		S_DUMP_OUT
	} state_t;

	// a link names a real node, not the null marker
	function automatic logic is_node(input link_t l);
		return l < NIL;
	endfunction

endpackage

// ===== rtl/clle_if.sv =====
// Interfaces: request and response channels of the linked list engine.
`timescale 1ns / 1ps

interface clle_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [clle_pkg::REQ_W-1:0]           req_type;
	logic signed [clle_pkg::VAL_W-1:0]    value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface clle_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [clle_pkg::STATUS_W-1:0]        status;
	logic [clle_pkg::SLOT_W-1:0]          slot;
	logic signed [clle_pkg::VAL_W-1:0]    elem_value;
	logic                                 last;

	modport source (output valid, output status, output slot, output elem_value,
		output last, input ready);
	modport sink   (input valid, input status, input slot, input elem_value,
		input last, output ready);
endinterface

// ===== rtl/clle_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module clle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port share the address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== rtl/cursor_linked_list_engine_core.sv =====
// Top level: sequencer, link store and free list of the linked list engine.
//
// Keeps one singly linked list of signed 32-bit values in a store of NODES
// nodes, unused nodes chained on a free list. Requests: insert at head, at
// tail, sorted (before the first node not smaller), delete first match, and
// dump. One request is handled at a time; req.ready is high only while the
// sequencer is idle. An insert at tail walks the list one link step per cycle;
// a sorted insert or delete visits each node with a value store read followed
// by a pass through the shared signed comparator; a dump reads and emits one
// element at a time. Links live in flip-flops and are restored on reset; node
// values sit in a single-port RAM.
`timescale 1ns / 1ps

module cursor_linked_list_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	clle_req_if.sink    req,
	clle_rsp_if.source  rsp
);

	import clle_pkg::*;

	state_t                 state_q, state_d;
	logic [REQ_W-1:0]       req_q;
	logic signed [VAL_W-1:0] val_q;
	idx_t                   n_q;
	link_t                  cur_q, prev_q, free_q, head_q;
	link_t                  next_q [NODES];
	cnt_t                   cnt_q;

	status_t                res_status_q;
	logic [SLOT_W-1:0]      res_slot_q;
	logic signed [VAL_W-1:0] res_value_q;

	logic                   rsp_valid_q;
	status_t                rsp_status_q;
	logic [SLOT_W-1:0]      rsp_slot_q;
	logic signed [VAL_W-1:0] rsp_value_q;
	logic                   rsp_last_q;

	logic                   ram_we, ram_re;
	idx_t                   ram_addr;
	logic [VAL_W-1:0]       ram_rdata;

	logic                   accept, out_free, cur_ok, gt, eq, dump_last, load_out;
	idx_t                   cur_idx, prev_idx, free_idx;
	link_t                  cur_next;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign cur_ok   = is_node(cur_q);
	assign cur_idx  = cur_q[IDX_W-1:0];
	assign prev_idx = prev_q[IDX_W-1:0];
	assign free_idx = free_q[IDX_W-1:0];
	assign cur_next = next_q[cur_idx];

	// shared signed comparator on the value just read
	assign gt = val_q > $signed(ram_rdata);
	assign eq = val_q == $signed(ram_rdata);

	assign dump_last = !is_node(cur_next) || (cnt_q == CNT_W'(DUMP_MAX - 1));

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.slot        = rsp_slot_q;
	assign rsp.elem_value  = rsp_value_q;
	assign rsp.last        = rsp_last_q;

	clle_ram #(
		.WIDTH (VAL_W),
		.DEPTH (NODES)
	) u_value_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (val_q),
		.rdata (ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and store controls
	always_comb begin
		state_d  = state_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = cur_idx;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_START;
				end
			end
			S_START: begin
				case (req_q)
					REQ_INS_HEAD: state_d = is_node(free_q) ? S_LINK : S_EMIT;
					REQ_INS_TAIL,
					REQ_INS_SORTED: state_d = is_node(free_q) ? S_WALK : S_EMIT;
					REQ_DELETE: state_d = S_WALK;
					REQ_DUMP: state_d = cur_ok ? S_DUMP_RD : S_EMIT;
					default: state_d = S_IDLE;
				endcase
			end
			S_WALK: begin
				if (!cur_ok) begin
					state_d = (req_q == REQ_DELETE) ? S_EMIT : S_LINK;
				end else if (req_q != REQ_INS_TAIL) begin
					ram_re  = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (req_q == REQ_DELETE) begin
					state_d = eq ? S_DEL : S_WALK;
				end else begin
					state_d = gt ? S_WALK : S_LINK;
				end
			end
			S_LINK: begin
				ram_we   = 1'b1;
				ram_addr = n_q;
				state_d  = S_EMIT;
			end
			S_DEL: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				ram_re  = 1'b1;
				state_d = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = dump_last ? S_IDLE : S_DUMP_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// cursors, free list and links
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= NIL;
			prev_q <= NIL;
			free_q <= LINK_W'(NODES - 1);
			head_q <= NIL;
			cnt_q  <= '0;
			for (int i = 0; i < NODES; i++) begin
				next_q[i] <= (i == 0) ? NIL : LINK_W'(i - 1);
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q  <= head_q;
						prev_q <= NIL;
						cnt_q  <= '0;
					end
				end
				S_START: begin
					// pop a node off the free list for an insert
					if ((req_q == REQ_INS_HEAD || req_q == REQ_INS_TAIL ||
						req_q == REQ_INS_SORTED) && is_node(free_q)) begin
						free_q <= next_q[free_idx];
					end
				end
				S_WALK: begin
					if (cur_ok && req_q == REQ_INS_TAIL) begin
						prev_q <= cur_q;
						cur_q  <= cur_next;
					end
				end
				S_CMP: begin
					if ((req_q == REQ_DELETE && !eq) || (req_q != REQ_DELETE && gt)) begin
						prev_q <= cur_q;
						cur_q  <= cur_next;
					end
				end
				S_LINK: begin
					// splice the new node in between prev and cur
					next_q[n_q] <= cur_q;
					if (is_node(prev_q)) begin
						next_q[prev_idx] <= {1'b0, n_q};
					end else begin
						head_q <= {1'b0, n_q};
					end
				end
				S_DEL: begin
					// unlink cur and push it on the free list
					if (is_node(prev_q)) begin
						next_q[prev_idx] <= cur_next;
					end else begin
						head_q <= cur_next;
					end
					next_q[cur_idx] <= free_q;
					free_q          <= cur_q;
				end
				S_DUMP_OUT: begin
					if (out_free) begin
						cur_q <= cur_next;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// request payload and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.req_type;
			val_q <= req.value;
		end
		case (state_q)
			S_START: begin
				n_q          <= free_idx;
				res_slot_q   <= '0;
				if (req_q == REQ_DUMP) begin
					res_status_q <= ST_EMPTY;
					res_value_q  <= '0;
				end else begin
					res_status_q <= ST_FULL;
					res_value_q  <= val_q;
				end
			end
			S_WALK: begin
				res_status_q <= ST_NOT_FOUND;
				res_slot_q   <= '0;
			end
			S_LINK: begin
				res_status_q <= ST_OK;
				res_slot_q   <= SLOT_W'(n_q);
			end
			S_DEL: begin
				res_status_q <= ST_OK;
				res_slot_q   <= SLOT_W'(cur_idx);
			end
			default: ;
		endcase
	end

	// response register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == S_DUMP_OUT) begin
				rsp_status_q <= ST_OK;
				rsp_slot_q   <= SLOT_W'(cur_idx);
				rsp_value_q  <= $signed(ram_rdata);
				rsp_last_q   <= dump_last;
			end else begin
				rsp_status_q <= res_status_q;
				rsp_slot_q   <= res_slot_q;
				rsp_value_q  <= res_value_q;
				rsp_last_q   <= 1'b1;
			end
		end
	end

endmodule

// ===== sim/cursor_linked_list_engine_core_tb.sv =====
// Testbench: list engine driven by a directed table and random requests, checked by a predictor.
`timescale 1ns / 1ps

module cursor_linked_list_engine_core_tb;
	import clle_pkg::*;

	// request codes the block leaves unused
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_UNUSED_MID = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI  = 3'd7;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT_CYCLES = 200000;
	localparam int IDLE_PCT     = 21;

	typedef struct {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic signed [31:0] elem;
		logic               last;
	} list_rsp_t;

	typedef struct {
		logic [REQ_W-1:0]   code;
		logic signed [31:0] v;
		int                 reps;
		bit                 typed;
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic signed [31:0] elem;
	} table_row_t;

	logic clk;
	logic arst_n;

	clle_req_if req_ch ();
	clle_rsp_if rsp_ch ();

	cursor_linked_list_engine_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the node store, links and free list
	logic signed [VAL_W-1:0] node_val  [NODES];
	link_t                   node_link [NODES];
	link_t                   free_top;
	link_t                   list_top;
	int                      occupancy;
	int                      peak_fill;

	list_rsp_t  pending_rsp [$];
	table_row_t stim_table  [$];

	int  errors;
	int  results_seen;
	int  items_sent;
	int  n_full, n_missed, n_empty;
	int  cycle_count;
	bit  calm;
	bit  stall_rsp;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// end the run if it hangs
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= LIMIT_CYCLES) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
					pending_rsp.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		$display("mismatch at result %0d, %s: expected %h got %h", results_seen, what, want, got);
		errors++;
	endtask

	function automatic void queue_result(input status_t st, input link_t slot,
		input logic signed [VAL_W-1:0] elem, input logic lst);
		list_rsp_t r;
		r.status = st;
		r.slot   = SLOT_W'(slot);
		r.elem   = elem;
		r.last   = lst;
		pending_rsp.push_back(r);
	endfunction

	// relink prv (or the list head when prv is null) to point at nxt
	function automatic void relink(input link_t prv, input link_t nxt);
		if (prv < NIL)
			node_link[prv[IDX_W-1:0]] = nxt;
		else
			list_top = nxt;
	endfunction

	// apply one request to the shadow list and queue the results it causes
	function automatic void predict_list_op(input logic [REQ_W-1:0] code,
		input logic signed [VAL_W-1:0] v);
		link_t prv, cur, n, nx;
		int    steps;
		prv = NIL;
		case (code)
			REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_SORTED: begin
				if (free_top >= NIL) begin
					n_full++;
					queue_result(ST_FULL, '0, v, 1'b1);
					return;
				end
				n = free_top;
				free_top = node_link[n[IDX_W-1:0]];
				cur = list_top;
				if (code != REQ_INS_HEAD) begin
					steps = 0;
					while (cur < NIL && steps < NODES) begin
						if (code == REQ_INS_SORTED && !(v > node_val[cur[IDX_W-1:0]]))
							break;
						prv = cur;
						cur = node_link[cur[IDX_W-1:0]];
						steps++;
					end
					if (cur >= NIL)
						cur = NIL;
				end
				node_val[n[IDX_W-1:0]]  = v;
				node_link[n[IDX_W-1:0]] = cur;
				relink(prv, n);
				occupancy++;
				if (occupancy > peak_fill)
					peak_fill = occupancy;
				queue_result(ST_OK, n, v, 1'b1);
			end
			REQ_DELETE: begin
				cur = list_top;
				steps = 0;
				while (cur < NIL && steps < NODES) begin
					if (node_val[cur[IDX_W-1:0]] == v)
						break;
					prv = cur;
					cur = node_link[cur[IDX_W-1:0]];
					steps++;
				end
				if (cur >= NIL || node_val[cur[IDX_W-1:0]] != v) begin
					n_missed++;
					queue_result(ST_NOT_FOUND, '0, v, 1'b1);
					return;
				end
				relink(prv, node_link[cur[IDX_W-1:0]]);
				node_link[cur[IDX_W-1:0]] = free_top;
				free_top = cur;
				occupancy--;
				queue_result(ST_OK, cur, v, 1'b1);
			end
			REQ_DUMP: begin
				cur = list_top;
				if (cur >= NIL) begin
					n_empty++;
					queue_result(ST_EMPTY, '0, '0, 1'b1);
					return;
				end
				steps = 0;
				while (cur < NIL && steps < DUMP_MAX) begin
					nx = node_link[cur[IDX_W-1:0]];
					queue_result(ST_OK, cur, node_val[cur[IDX_W-1:0]],
						(nx >= NIL) || (steps + 1 >= DUMP_MAX));
					steps++;
					cur = nx;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return int'($urandom_range(0, 8)) - 4;
		if (r < 55) begin
			case ($urandom_range(0, 3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return -1;
				default: return 0;
			endcase
		end
		return $urandom;
	endfunction

	function automatic void add_row(input logic [REQ_W-1:0] code,
		input logic signed [31:0] v, input int reps, input bit typed, input status_t st,
		input logic [SLOT_W-1:0] slot, input logic signed [31:0] elem);
		table_row_t row;
		row.code   = code;
		row.v      = v;
		row.reps   = reps;
		row.typed  = typed;
		row.status = st;
		row.slot   = slot;
		row.elem   = elem;
		stim_table.push_back(row);
	endfunction

	// offer one item, wait for the handshake, then predict its results
	task automatic send_item(input logic [REQ_W-1:0] code, input logic signed [VAL_W-1:0] v);
		int gap;
		gap = 0;
		if (!calm && !stall_rsp && $urandom_range(0, 99) < IDLE_PCT)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= code;
		req_ch.value    <= v;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		predict_list_op(code, v);
	endtask

	// result side: check each accepted result, stall at random
	initial begin
		list_rsp_t e;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("result with no item pending", '0, rsp_ch.elem_value);
				end else begin
					e = pending_rsp.pop_front();
					if (rsp_ch.status !== e.status)
						report_mismatch("status", 32'(e.status), 32'(rsp_ch.status));
					if (rsp_ch.slot !== e.slot)
						report_mismatch("slot", 32'(e.slot), 32'(rsp_ch.slot));
					if (rsp_ch.elem_value !== e.elem)
						report_mismatch("elem_value", e.elem, rsp_ch.elem_value);
					if (rsp_ch.last !== e.last)
						report_mismatch("last", 32'(e.last), 32'(rsp_ch.last));
				end
				results_seen++;
			end
			// hold off for a long stretch so the request side backs up
			if (stall_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_rsp = 1'b0;
			end
			rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// request side: reset, directed table, random traffic, drain
	initial begin
		table_row_t         row;
		list_rsp_t          typed_rsp;
		logic [REQ_W-1:0]   code;
		logic signed [31:0] v;
		link_t              cur;
		int                 r, k, n_random, n_directed;

		errors       = 0;
		results_seen = 0;
		items_sent   = 0;
		n_full       = 0;
		n_missed     = 0;
		n_empty      = 0;
		occupancy    = 0;
		peak_fill    = 0;
		calm         = 1'b0;
		stall_rsp    = 1'b0;

		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_INS_HEAD;
		req_ch.value    <= '0;

		// shadow state after reset: every node chained on the free list
		for (k = 0; k < NODES; k++) begin
			node_val[k]  = '0;
			node_link[k] = (k == 0) ? NIL : link_t'(k - 1);
		end
		free_top = link_t'(NODES - 1);
		list_top = NIL;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table; typed rows carry the result read straight off the spec
		add_row(REQ_DUMP,       32'sd77,  1, 1, ST_EMPTY,     '0, 32'sd0);
		add_row(REQ_DELETE,     32'sd5,   1, 1, ST_NOT_FOUND, '0, 32'sd5);
		add_row(REQ_INS_HEAD,   VAL_MAX,  1, 1, ST_OK, SLOT_W'(NODES - 1), VAL_MAX);
		add_row(REQ_INS_TAIL,   VAL_MIN,  1, 1, ST_OK, SLOT_W'(NODES - 2), VAL_MIN);
		add_row(REQ_INS_SORTED, 32'sd0,   1, 0, ST_OK, '0, '0);
		add_row(REQ_DELETE,     VAL_MIN,  1, 0, ST_OK, '0, '0);
		add_row(REQ_UNUSED_LO,  32'sd1,   1, 0, ST_OK, '0, '0);
		add_row(REQ_UNUSED_MID, -32'sd1,  1, 0, ST_OK, '0, '0);
		add_row(REQ_UNUSED_HI,  VAL_MIN,  1, 0, ST_OK, '0, '0);
		// fill with sorted inserts; the first one ties with an existing zero
		add_row(REQ_INS_SORTED, 32'sd0,  13, 0, ST_OK, '0, '0);
		add_row(REQ_INS_TAIL,   -32'sd100, 1, 0, ST_OK, '0, '0);
		add_row(REQ_INS_HEAD,   32'sd55,  1, 1, ST_FULL, '0, 32'sd55);
		add_row(REQ_INS_TAIL,   VAL_MIN,  1, 1, ST_FULL, '0, VAL_MIN);
		add_row(REQ_INS_SORTED, VAL_MAX,  1, 1, ST_FULL, '0, VAL_MAX);
		add_row(REQ_DUMP,       32'sd0,   1, 0, ST_OK, '0, '0);
		add_row(REQ_DELETE,     -32'sd100, 1, 0, ST_OK, '0, '0);
		add_row(REQ_INS_SORTED, VAL_MAX,  1, 0, ST_OK, '0, '0);
		add_row(REQ_DELETE,     32'sd0,   1, 0, ST_OK, '0, '0);
		add_row(REQ_DUMP,       -32'sd1,  1, 0, ST_OK, '0, '0);

		foreach (stim_table[i]) begin
			row = stim_table[i];
			for (k = 0; k < row.reps; k++) begin
				send_item(row.code, row.v + k);
				if (row.typed) begin
					// swap the predicted result for the one typed in the table
					void'(pending_rsp.pop_back());
					typed_rsp.status = row.status;
					typed_rsp.slot   = row.slot;
					typed_rsp.elem   = row.elem;
					typed_rsp.last   = 1'b1;
					pending_rsp.push_back(typed_rsp);
				end
			end
		end
		n_directed = items_sent;

		// random traffic, weighted to keep the list between empty and full
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			if (n_random == 60)
				stall_rsp = 1'b1;
			calm = (n_random >= 90 && n_random < 130);
			if (n_random == 150) begin
				// pause until every outstanding result has drained
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (pending_rsp.size() != 0);
			end
			r = $urandom_range(0, 99);
			v = pick_value();
			if (r < 3) begin
				code = REQ_W'(REQ_UNUSED_LO +
					$urandom_range(0, REQ_UNUSED_HI - REQ_UNUSED_LO));
				send_item(code, $urandom);
				continue;
			end
			if (r < 13) begin
				code = REQ_DUMP;
			end else begin
				r = $urandom_range(0, 99);
				if (occupancy >= NODES - 2)
					code = (r < 70) ? REQ_DELETE : REQ_INS_HEAD;
				else if (occupancy <= 2)
					code = (r < 25) ? REQ_DELETE : REQ_INS_TAIL;
				else
					code = (r < 45) ? REQ_DELETE : REQ_INS_SORTED;
				// spread inserts over all three kinds
				if (code != REQ_DELETE)
					code = REQ_W'(REQ_INS_HEAD +
						$urandom_range(0, REQ_INS_SORTED - REQ_INS_HEAD));
				// deletes mostly target a value that is in the list
				if (code == REQ_DELETE && occupancy > 0 && $urandom_range(0, 99) < 75) begin
					cur = list_top;
					repeat ($urandom_range(0, occupancy - 1))
						cur = node_link[cur[IDX_W-1:0]];
					v = node_val[cur[IDX_W-1:0]];
				end
			end
			send_item(code, v);
			n_random++;
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		// drain, then allow the block to settle
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d requests (%0d from the table), checked %0d results, peak fill %0d",
			items_sent, n_directed, results_seen, peak_fill);
		$display("full inserts %0d, missed deletes %0d, empty dumps %0d, mismatches %0d",
			n_full, n_missed, n_empty, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/clle_pkg.sv
rtl/clle_if.sv
rtl/clle_ram.sv
rtl/cursor_linked_list_engine_core.sv
sim/cursor_linked_list_engine_core_tb.sv
